// ===== src/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

    localparam int MAX_COLS  = 80;
    localparam int MAX_ROWS  = 25;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CH_W      = 8;
    localparam int CELL_W    = 2 * CH_W;
    // geometry counts are one bit wider than a cursor position
    localparam int COLS_CW   = COL_W + 1;
    localparam int ROWS_CW   = ROW_W + 1;
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;
    localparam int QDEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

    localparam logic [CH_W-1:0]   BLANK_COLOR = 8'h0f;
    localparam logic [CH_W-1:0]   CH_NUL      = 8'h00;
    localparam logic [CH_W-1:0]   CH_BS       = 8'h08;
    localparam logic [CH_W-1:0]   CH_NL       = 8'h0a;
    localparam logic [CH_W-1:0]   CH_SPACE    = 8'h20;
    localparam logic [CELL_W-1:0] BLANK_CELL  = {BLANK_COLOR, CH_NUL};

    typedef enum logic [1:0] {
        REQ_PUT       = 2'd0,
        REQ_PUT_COLOR = 2'd1,
        REQ_READ      = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT_KEEP,
        OP_PUT_COLOR,
        OP_READ,
        OP_SCROLL
    } t_op;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_MERGE,
        BS_RESP,
        BS_SCR_RD,
        BS_SCR_WR,
        BS_BLANK
    } t_bstate;

    typedef struct packed {
        t_op               op;
        logic [CH_W-1:0]   ch;
        logic [CH_W-1:0]   color;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
    } t_cmd;

    typedef struct packed {
        logic [COLS_CW-1:0] cols;
        logic [ROWS_CW-1:0] rows;
    } t_geom;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

    function automatic logic [COLS_CW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [COLS_CW-1:0] res;
        if (v == '0) begin
            res = COLS_CW'(1);
        end else if (int'(v) > MAX_COLS) begin
            res = COLS_CW'(MAX_COLS);
        end else begin
            res = COLS_CW'(v);
        end
        return res;
    endfunction

    function automatic logic [ROWS_CW-1:0] clamp_rows(input logic [ROW_W-1:0] v);
        logic [ROWS_CW-1:0] res;
        if (v == '0) begin
            res = ROWS_CW'(1);
        end else if (int'(v) > MAX_ROWS) begin
            res = ROWS_CW'(MAX_ROWS);
        end else begin
            res = ROWS_CW'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/text_console_cursor_scroll_unit.sv =====
// Teletype engine over an 80x25 character/attribute cell store.
// Input channel: i_valid / o_stall with i_req_type, i_ch, i_color,
// i_cell_col, i_cell_row. A transfer happens when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall with the cursor after
// the request, the read cell (zero unless a read) and the scroll flag.
// Geometry is set through i_cfg_we / i_cfg_idx / i_cfg_data; the user is
// to write it only while idle, which the block itself does not enforce.
// The front keeps the cursor and classifies each request; a two-entry
// command queue feeds the back, which owns the single-write, single-read
// cell memory and the result register. Keep-color put and cell read go
// through the registered memory read port (read-modify-write for the put);
// a scrolling newline copies the active rows up one row through that port
// and then blanks the last active row. A request is written into the queue
// at its transfer and waits there while the back is busy or the result is
// held; the result shows on the output in the cycle after the back finishes it.
// After reset the back clears all 2000 cells, one per cycle, and holds
// o_stall high while it does so; configuration writes are taken.
// When i_stall holds the result, the back finishes no further request and
// the queue fills, after which o_stall goes high.
`default_nettype none

module text_console_cursor_scroll_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [tccs_pkg::CH_W-1:0]       i_ch,
    input  wire logic [tccs_pkg::CH_W-1:0]       i_color,
    input  wire logic [tccs_pkg::COL_W-1:0]      i_cell_col,
    input  wire logic [tccs_pkg::ROW_W-1:0]      i_cell_row,
    input  wire logic                            i_cfg_we,
    input  wire logic [tccs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tccs_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [tccs_pkg::COL_W-1:0]           o_cursor_col,
    output logic [tccs_pkg::ROW_W-1:0]           o_cursor_row,
    output logic [tccs_pkg::CH_W-1:0]            o_read_char,
    output logic [tccs_pkg::CH_W-1:0]            o_read_color,
    output logic                                 o_scrolled
);
    import tccs_pkg::*;

    t_cmd  push_cmd, pop_cmd;
    t_geom geom;
    logic  push, pop, q_full, q_empty, clearing;

    tccs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_ch       (i_ch),
        .i_color    (i_color),
        .i_cell_col (i_cell_col),
        .i_cell_row (i_cell_row),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_geom     (geom)
    );

    tccs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_cmd),
        .o_empty     (q_empty)
    );

    tccs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_q_empty    (q_empty),
        .i_q_data     (pop_cmd),
        .o_q_pop      (pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_read_char  (o_read_char),
        .o_read_color (o_read_color),
        .o_scrolled   (o_scrolled)
    );

endmodule

`default_nettype wire

// ===== src/tccs_queue.sv =====
`default_nettype none

module tccs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  tccs_pkg::t_cmd     i_push_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output tccs_pkg::t_cmd     o_pop_data,
    output logic               o_empty
);
    import tccs_pkg::*;

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    t_cmd              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == QCNT_W'(QDEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("queue push while full");

endmodule

`default_nettype wire

// ===== src/tccs_front.sv =====
`default_nettype none

module tccs_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [tccs_pkg::CH_W-1:0]       i_ch,
    input  wire logic [tccs_pkg::CH_W-1:0]       i_color,
    input  wire logic [tccs_pkg::COL_W-1:0]      i_cell_col,
    input  wire logic [tccs_pkg::ROW_W-1:0]      i_cell_row,
    input  wire logic                            i_cfg_we,
    input  wire logic [tccs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tccs_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_q_full,
    input  wire logic                            i_clearing,
    output logic                                 o_push,
    output tccs_pkg::t_cmd                       o_cmd,
    output tccs_pkg::t_geom                      o_geom
);
    import tccs_pkg::*;

    t_geom              r_geom, n_geom;
    logic [COL_W-1:0]   r_ccol, n_ccol;
    logic [ROW_W-1:0]   r_crow, n_crow;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [COLS_CW-1:0] cols_m1, cfg_cols, cfg_cols_m1;
    logic [ROWS_CW-1:0] rows_m1, cfg_rows, cfg_rows_m1;
    logic               col_last, row_last, accept;
    t_req               req;
    t_cmd               cmd;

    assign o_stall = i_q_full || i_clearing;
    assign accept  = i_valid && !o_stall;
    assign o_push  = accept;
    assign o_cmd   = cmd;
    assign o_geom  = r_geom;
    assign req     = t_req'(i_req_type);

    assign cols_m1  = r_geom.cols - COLS_CW'(1);
    assign rows_m1  = r_geom.rows - ROWS_CW'(1);
    assign col_last = ({1'b0, r_ccol} == cols_m1);
    assign row_last = ({1'b0, r_crow} == rows_m1);

    // classify the request and work out where the cursor lands
    always_comb begin
        n_ccol    = r_ccol;
        n_crow    = r_crow;
        cmd.op    = OP_NONE;
        cmd.ch    = i_ch;
        cmd.color = i_color;
        cmd.addr  = cell_addr(r_crow, r_ccol);
        unique case (req) inside
            REQ_PUT, REQ_PUT_COLOR: begin
                if (i_ch == CH_NL) begin
                    n_ccol = '0;
                    if (row_last) begin
                        cmd.op = OP_SCROLL;
                    end else begin
                        n_crow = r_crow + ROW_W'(1);
                    end
                end else if (i_ch == CH_BS && req == REQ_PUT) begin
                    if (r_ccol == '0) begin
                        if (r_crow != '0) begin
                            n_crow = r_crow - ROW_W'(1);
                            n_ccol = cols_m1[COL_W-1:0];
                        end
                    end else begin
                        n_ccol = r_ccol - COL_W'(1);
                    end
                    cmd.op   = OP_PUT_KEEP;
                    cmd.ch   = CH_SPACE;
                    cmd.addr = cell_addr(n_crow, n_ccol);
                end else begin
                    if (i_ch != CH_NUL) begin
                        cmd.op = (req == REQ_PUT_COLOR) ? OP_PUT_COLOR : OP_PUT_KEEP;
                    end
                    if (col_last) begin
                        n_ccol = '0;
                        if (!row_last) begin
                            n_crow = r_crow + ROW_W'(1);
                        end
                    end else begin
                        n_ccol = r_ccol + COL_W'(1);
                    end
                end
            end
            REQ_READ: begin
                if ({1'b0, i_cell_col} < r_geom.cols && {1'b0, i_cell_row} < r_geom.rows) begin
                    cmd.op   = OP_READ;
                    cmd.addr = cell_addr(i_cell_row, i_cell_col);
                end
            end
            default: ;
        endcase
        cmd.cur_col = n_ccol;
        cmd.cur_row = n_crow;
    end

    // geometry writes pull the cursor back into the active area
    assign cfg_cols    = clamp_cols(i_cfg_data);
    assign cfg_rows    = clamp_rows(i_cfg_data[ROW_W-1:0]);
    assign cfg_cols_m1 = cfg_cols - COLS_CW'(1);
    assign cfg_rows_m1 = cfg_rows - ROWS_CW'(1);

    always_comb begin
        n_geom = r_geom;
        n_col  = r_ccol;
        n_row  = r_crow;
        if (accept) begin
            n_col = n_ccol;
            n_row = n_crow;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLS: begin
                    n_geom.cols = cfg_cols;
                    if ({1'b0, r_ccol} >= cfg_cols) begin
                        n_col = cfg_cols_m1[COL_W-1:0];
                    end
                end
                REG_ROWS: begin
                    n_geom.rows = cfg_rows;
                    if ({1'b0, r_crow} >= cfg_rows) begin
                        n_row = cfg_rows_m1[ROW_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.cols <= COLS_CW'(MAX_COLS);
            r_geom.rows <= ROWS_CW'(MAX_ROWS);
            r_ccol      <= '0;
            r_crow      <= '0;
        end else begin
            r_geom <= n_geom;
            r_ccol <= n_col;
            r_crow <= n_row;
        end
    end

    a_cursor_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ccol} < r_geom.cols) && ({1'b0, r_crow} < r_geom.rows))
        else $error("cursor outside active area");

endmodule

`default_nettype wire

// ===== src/tccs_back.sv =====
`default_nettype none

module tccs_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  tccs_pkg::t_geom                  i_geom,
    input  wire logic                        i_q_empty,
    input  tccs_pkg::t_cmd                   i_q_data,
    output logic                             o_q_pop,
    output logic                             o_clearing,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [tccs_pkg::COL_W-1:0]       o_cursor_col,
    output logic [tccs_pkg::ROW_W-1:0]       o_cursor_row,
    output logic [tccs_pkg::CH_W-1:0]        o_read_char,
    output logic [tccs_pkg::CH_W-1:0]        o_read_color,
    output logic                             o_scrolled
);
    import tccs_pkg::*;

    logic [CELL_W-1:0]  mem [CELLS];
    logic [CELL_W-1:0]  r_rd_data;

    t_bstate            r_state, n_state;
    t_cmd               r_cmd, out_cmd;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_clr;
    logic [ADDR_W-1:0]  walk_addr;
    logic [COLS_CW-1:0] cols_m1;
    logic [ROWS_CW-1:0] rows_m2;
    logic               col_last, move_last, out_free;

    logic               mem_we, rd_en, load_out;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [CELL_W-1:0]  wr_data;
    logic [CH_W-1:0]    out_char, out_color;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [CH_W-1:0]    r_out_char, r_out_color;
    logic               r_out_scr;

    assign walk_addr = r_base + ADDR_W'(r_col);
    assign cols_m1   = i_geom.cols - COLS_CW'(1);
    assign rows_m2   = i_geom.rows - ROWS_CW'(2);
    assign col_last  = ({1'b0, r_col} == cols_m1);
    assign move_last = ({1'b0, r_row} == rows_m2);
    assign out_free  = !r_out_valid || !i_stall;
    assign out_cmd   = (r_state == BS_IDLE) ? i_q_data : r_cmd;
    assign o_clearing = (r_state == BS_CLEAR);

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            BS_CLEAR: begin
                if (r_clr == ADDR_W'(CELLS - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_q_empty && out_free) begin
                    unique case (i_q_data.op)
                        OP_PUT_KEEP: n_state = BS_MERGE;
                        OP_READ:     n_state = BS_RESP;
                        OP_SCROLL: begin
                            n_state = (i_geom.rows == ROWS_CW'(1)) ? BS_BLANK : BS_SCR_RD;
                        end
                        default:     n_state = BS_IDLE;
                    endcase
                end
            end
            BS_MERGE, BS_RESP: n_state = BS_IDLE;
            BS_SCR_RD:         n_state = BS_SCR_WR;
            BS_SCR_WR: begin
                n_state = (col_last && move_last) ? BS_BLANK : BS_SCR_RD;
            end
            BS_BLANK: begin
                if (col_last) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        wr_addr   = walk_addr;
        wr_data   = BLANK_CELL;
        rd_en     = 1'b0;
        rd_addr   = i_q_data.addr;
        o_q_pop   = 1'b0;
        load_out  = 1'b0;
        out_char  = '0;
        out_color = '0;
        unique case (r_state)
            BS_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr;
            end
            BS_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_data.op) inside
                        OP_NONE: load_out = 1'b1;
                        OP_PUT_COLOR: begin
                            mem_we   = 1'b1;
                            wr_addr  = i_q_data.addr;
                            wr_data  = {i_q_data.color, i_q_data.ch};
                            load_out = 1'b1;
                        end
                        OP_PUT_KEEP, OP_READ: rd_en = 1'b1;
                        default: ;
                    endcase
                end
            end
            BS_MERGE: begin
                // keep the stored color, replace the character
                mem_we   = 1'b1;
                wr_addr  = r_cmd.addr;
                wr_data  = {r_rd_data[CELL_W-1:CH_W], r_cmd.ch};
                load_out = 1'b1;
            end
            BS_RESP: begin
                load_out  = 1'b1;
                out_char  = r_rd_data[CH_W-1:0];
                out_color = r_rd_data[CELL_W-1:CH_W];
            end
            BS_SCR_RD: begin
                rd_en   = 1'b1;
                rd_addr = walk_addr + ADDR_W'(MAX_COLS);
            end
            BS_SCR_WR: begin
                mem_we  = 1'b1;
                wr_data = r_rd_data;
            end
            BS_BLANK: begin
                mem_we   = 1'b1;
                load_out = col_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scroll walk position and the command under way
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_q_data;
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (r_state == BS_SCR_WR) begin
            if (col_last) begin
                r_col  <= '0;
                r_row  <= r_row + ROW_W'(1);
                r_base <= r_base + ADDR_W'(MAX_COLS);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end else if (r_state == BS_BLANK) begin
            r_col <= r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_col   <= out_cmd.cur_col;
            r_out_row   <= out_cmd.cur_row;
            r_out_char  <= out_char;
            r_out_color <= out_color;
            r_out_scr   <= (out_cmd.op == OP_SCROLL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_read_char  = r_out_char;
    assign o_read_color = r_out_color;
    assign o_scrolled   = r_out_scr;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !(r_out_valid && i_stall))
        else $error("result register overwritten while held");

    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> (!o_q_pop && !load_out))
        else $error("command taken during the clearing pass");

    a_scroll_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_BLANK && load_out) |=> (r_out_valid && r_out_scr))
        else $error("scroll finished without a scroll result");

endmodule

`default_nettype wire

// ===== tb/text_console_cursor_scroll_unit_test.sv =====
`timescale 1ns / 100ps

module text_console_cursor_scroll_unit_test;
    import tccs_pkg::*;

    // request code outside the defined set, the block must ignore it
    localparam logic [1:0]           REQ_IGNORED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = CFG_IDX_W'(3);

    typedef struct {
        logic [1:0]       kind;
        logic [CH_W-1:0]  ch;
        logic [CH_W-1:0]  color;
        logic [COL_W-1:0] cell_col;
        logic [ROW_W-1:0] cell_row;
    } t_tty_request;

    typedef struct {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [CH_W-1:0]  read_char;
        logic [CH_W-1:0]  read_color;
        logic             scrolled;
    } t_tty_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_req_type;
    logic [CH_W-1:0]      i_ch;
    logic [CH_W-1:0]      i_color;
    logic [COL_W-1:0]     i_cell_col;
    logic [ROW_W-1:0]     i_cell_row;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic                 i_stall;
    logic [COL_W-1:0]     o_cursor_col;
    logic [ROW_W-1:0]     o_cursor_row;
    logic [CH_W-1:0]      o_read_char;
    logic [CH_W-1:0]      o_read_color;
    logic                 o_scrolled;

    // shadow of the screen, cursor and geometry
    logic [CH_W-1:0] scr_char [MAX_ROWS][MAX_COLS];
    logic [CH_W-1:0] scr_attr [MAX_ROWS][MAX_COLS];
    int              cur_x;
    int              cur_y;
    int              cols_active;
    int              rows_active;

    t_tty_report     expected_reports[$];
    int              errors        = 0;
    int              sent_count    = 0;
    int              checked_count = 0;
    int              scroll_count  = 0;
    int              setting_count = 0;
    bit              allow_idle    = 1'b1;

    text_console_cursor_scroll_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_ch         (i_ch),
        .i_color      (i_color),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_read_char  (o_read_char),
        .o_read_color (o_read_color),
        .o_scrolled   (o_scrolled)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void reset_screen_model();
        for (int r = 0; r < MAX_ROWS; r++) begin
            for (int c = 0; c < MAX_COLS; c++) begin
                scr_char[r][c] = CH_NUL;
                scr_attr[r][c] = BLANK_COLOR;
            end
        end
        cur_x       = 0;
        cur_y       = 0;
        cols_active = MAX_COLS;
        rows_active = MAX_ROWS;
    endfunction

    function automatic void apply_geometry_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_W-1:0] data);
        int v;
        if (idx == REG_COLS) begin
            v = int'(data);
            cols_active = (v == 0) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
        end else if (idx == REG_ROWS) begin
            v = int'(data[ROW_W-1:0]);
            rows_active = (v == 0) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
        end else begin
            return;
        end
        // a shrunk screen pulls the cursor inside
        if (cur_x >= cols_active) cur_x = cols_active - 1;
        if (cur_y >= rows_active) cur_y = rows_active - 1;
    endfunction

    function automatic void scroll_screen_model();
        for (int r = 0; r + 1 < rows_active; r++) begin
            for (int c = 0; c < cols_active; c++) begin
                scr_char[r][c] = scr_char[r + 1][c];
                scr_attr[r][c] = scr_attr[r + 1][c];
            end
        end
        for (int c = 0; c < cols_active; c++) begin
            scr_char[rows_active - 1][c] = CH_NUL;
            scr_attr[rows_active - 1][c] = BLANK_COLOR;
        end
    endfunction

    function automatic t_tty_report teletype_step(input t_tty_request rq);
        t_tty_report rep;
        bit          is_put;
        rep.read_char  = '0;
        rep.read_color = '0;
        rep.scrolled   = 1'b0;
        is_put = (rq.kind == REQ_PUT) || (rq.kind == REQ_PUT_COLOR);
        if (is_put && rq.ch == CH_NL) begin
            cur_x = 0;
            if (cur_y + 1 >= rows_active) begin
                scroll_screen_model();
                rep.scrolled = 1'b1;
            end else begin
                cur_y++;
            end
        end else if (rq.kind == REQ_PUT && rq.ch == CH_BS) begin
            if (cur_x != 0) begin
                cur_x--;
            end else if (cur_y != 0) begin
                cur_y--;
                cur_x = cols_active - 1;
            end
            scr_char[cur_y][cur_x] = CH_SPACE;
        end else if (is_put) begin
            if (rq.ch != CH_NUL) begin
                scr_char[cur_y][cur_x] = rq.ch;
                if (rq.kind == REQ_PUT_COLOR) scr_attr[cur_y][cur_x] = rq.color;
            end
            cur_x++;
            if (cur_x >= cols_active) begin
                cur_x = 0;
                cur_y++;
            end
            // past the bottom the cursor sticks to the last row
            if (cur_y >= rows_active) cur_y = rows_active - 1;
        end else if (rq.kind == REQ_READ) begin
            if (int'(rq.cell_col) < cols_active && int'(rq.cell_row) < rows_active) begin
                rep.read_char  = scr_char[rq.cell_row][rq.cell_col];
                rep.read_color = scr_attr[rq.cell_row][rq.cell_col];
            end
        end
        rep.cursor_col = COL_W'(cur_x);
        rep.cursor_row = ROW_W'(cur_y);
        return rep;
    endfunction

    function automatic t_tty_request tty_req(input logic [1:0] kind, input logic [CH_W-1:0] ch,
                                             input logic [CH_W-1:0] color,
                                             input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row);
        t_tty_request rq;
        rq.kind     = kind;
        rq.ch       = ch;
        rq.color    = color;
        rq.cell_col = col;
        rq.cell_row = row;
        return rq;
    endfunction

    function automatic t_tty_request random_request(input int newline_pct);
        t_tty_request rq;
        int           pick;
        int           sub;
        rq.ch       = CH_W'($urandom);
        rq.color    = CH_W'($urandom);
        rq.cell_col = COL_W'($urandom);
        rq.cell_row = ROW_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            rq.kind = REQ_IGNORED;
        end else if (pick < 27) begin
            rq.kind = REQ_READ;
            // mostly inside the active screen, now and then anywhere
            if ($urandom_range(0, 4) != 0) begin
                rq.cell_col = COL_W'($urandom_range(0, cols_active - 1));
                rq.cell_row = ROW_W'($urandom_range(0, rows_active - 1));
            end
        end else begin
            rq.kind = ($urandom_range(0, 99) < 55) ? REQ_PUT : REQ_PUT_COLOR;
            sub = $urandom_range(0, 99);
            if (sub < newline_pct) begin
                rq.ch = CH_NL;
            end else if (sub < newline_pct + 6) begin
                rq.ch = CH_BS;
            end else if (sub < newline_pct + 9) begin
                rq.ch = CH_NUL;
            end else if (sub >= newline_pct + 20) begin
                rq.ch = CH_W'($urandom_range(32, 126));
            end
        end
        return rq;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // every task below starts and ends just after a falling edge
    task automatic send_request(input t_tty_request rq);
        i_valid    <= 1'b1;
        i_req_type <= rq.kind;
        i_ch       <= rq.ch;
        i_color    <= rq.color;
        i_cell_col <= rq.cell_col;
        i_cell_row <= rq.cell_row;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_reports.push_back(teletype_step(rq));
        sent_count++;
        @(negedge i_clk);
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_geometry_write(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input int cols, input int rows);
        wait_results_done();
        write_reg(REG_COLS, CFG_W'(cols));
        write_reg(REG_ROWS, CFG_W'(rows));
        setting_count++;
    endtask

    task automatic test_after_reset();
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd24));
        send_request(tty_req(REQ_READ, 8'hff, 8'hff, 7'h7f, 5'h1f));
    endtask

    task automatic test_put_modes();
        send_request(tty_req(REQ_PUT, 8'h41, 8'h5a, 7'h7f, 5'h1f));
        send_request(tty_req(REQ_PUT_COLOR, 8'h42, 8'hff, 7'h00, 5'h00));
        // in colored mode the backspace byte is just a glyph
        send_request(tty_req(REQ_PUT_COLOR, CH_BS, 8'h00, 7'h55, 5'h0a));
        send_request(tty_req(REQ_PUT, CH_NUL, 8'hc3, 7'h2a, 5'h15));
        send_request(tty_req(REQ_PUT_COLOR, CH_NUL, 8'haa, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT_COLOR, 8'hff, 8'h80, 7'h00, 5'h00));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd1, 5'd0));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd2, 5'd0));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd3, 5'd0));
    endtask

    task automatic test_backspace();
        send_request(tty_req(REQ_PUT, CH_BS, 8'hff, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT, CH_NL, 8'h00, 7'h00, 5'h00));
        // from column 0 it wraps to the end of the row above
        send_request(tty_req(REQ_PUT, CH_BS, 8'h00, 7'h00, 5'h00));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd4, 5'd0));
    endtask

    task automatic test_ignored_request();
        send_request(tty_req(REQ_IGNORED, 8'h41, 8'hff, 7'd0, 5'd0));
    endtask

    task automatic test_geometry_and_scroll();
        // zero counts as one, a single cell screen
        set_geometry(0, 0);
        send_request(tty_req(REQ_PUT_COLOR, 8'h5a, 8'h3c, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT, CH_BS, 8'h00, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT_COLOR, CH_NL, 8'h00, 7'h00, 5'h00));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        set_geometry(6, 2);
        send_request(tty_req(REQ_PUT, 8'h78, 8'h00, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT, CH_NL, 8'h00, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT_COLOR, 8'h79, 8'h17, 7'h00, 5'h00));
        send_request(tty_req(REQ_PUT_COLOR, CH_NL, 8'h00, 7'h00, 5'h00));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd0));
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd0, 5'd1));
        // oversized counts clamp to the full screen
        set_geometry(127, 127);
        write_reg(REG_SPARE, 7'h55);
        send_request(tty_req(REQ_READ, 8'h00, 8'h00, 7'd79, 5'd0));
    endtask

    task automatic run_traffic_phase(input int cols, input int rows, input int count,
                                     input int newline_pct);
        set_geometry(cols, rows);
        for (int n = 0; n < count; n++) begin
            send_request(random_request(newline_pct));
            if ($urandom_range(0, 149) == 0) wait_results_done();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(80, 25, 120, 30);
        run_traffic_phase(1, 1, 130, 10);
        run_traffic_phase(8, 4, 130, 12);
        run_traffic_phase(40, 12, 130, 10);
        allow_idle = 1'b0;
        run_traffic_phase(3, 2, 130, 10);
        allow_idle = 1'b1;
        run_traffic_phase(80, 1, 130, 10);
        run_traffic_phase(1, 25, 130, 10);
        run_traffic_phase(17, 5, 130, 10);
        run_traffic_phase(5, 3, 130, 10);
        run_traffic_phase(64, 2, 130, 10);
        run_traffic_phase($urandom_range(1, 80), $urandom_range(1, 6), 130, 10);
        run_traffic_phase($urandom_range(1, 20), $urandom_range(1, 25), 130, 10);
    endtask

    task automatic test_unthrottled_tail();
        allow_idle = 1'b0;
        run_traffic_phase(12, 3, 120, 10);
    endtask

    initial begin : stall_driver
        int hold;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 9);
            end
            i_stall <= (hold > 0);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tty_report want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, cursor %0d,%0d",
                         $time, o_cursor_col, o_cursor_row);
            end else begin
                want = expected_reports.pop_front();
                check_field("cursor_col", 8'(want.cursor_col), 8'(o_cursor_col));
                check_field("cursor_row", 8'(want.cursor_row), 8'(o_cursor_row));
                check_field("read_char", want.read_char, o_read_char);
                check_field("read_color", want.read_color, o_read_color);
                check_field("scrolled", 8'(want.scrolled), 8'(o_scrolled));
                checked_count++;
                if (want.scrolled) scroll_count++;
            end
        end
    end

    initial begin : watchdog
        #100_000_000;
        $display("%0t: timed out, %0d results outstanding", $time, expected_reports.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : main_sequence
        int waited;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = '0;
        i_ch       = '0;
        i_color    = '0;
        i_cell_col = '0;
        i_cell_row = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        reset_screen_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_after_reset();
        test_put_modes();
        test_backspace();
        test_ignored_request();
        test_geometry_and_scroll();
        test_random_traffic();
        test_unthrottled_tail();

        i_valid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        // catch any stray transfer after the last one
        repeat (40) @(negedge i_clk);
        if (expected_reports.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
        end
        $display("sent %0d requests over %0d screen geometries", sent_count, setting_count);
        $display("checked %0d results, %0d of them scrolls", checked_count, scroll_count);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
